/* design/tapc_pkg.sv */
// Shared types and constants for the three-axis PID controller.
package tapc_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned AXES      = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ADDR_W    = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_TARGET_X = 3'd3,
    REG_TARGET_Y = 3'd4,
    REG_TARGET_Z = 3'd5
  } tapc_reg_t;

  typedef struct packed {
    logic acc;
    logic adv;
  } tapc_lane_ctrl_t;

  typedef struct packed {
    word_t d;
    word_t i;
    word_t p;
  } tapc_terms_t;

endpackage

/* design/tapc_lane.sv */
// One axis of the PID datapath: error update, then the three gain products.
module tapc_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tapc_pkg::tapc_lane_ctrl_t ctrl,
  input  tapc_pkg::word_t           angle,
  input  tapc_pkg::word_t           target,
  input  tapc_pkg::word_t           gain_p,
  input  tapc_pkg::word_t           gain_i,
  input  tapc_pkg::word_t           gain_d,
  output tapc_pkg::tapc_terms_t     terms
);

  tapc_pkg::word_t error_sum_r;
  tapc_pkg::word_t prev_err_r;
  tapc_pkg::word_t err_nxt;
  tapc_pkg::word_t sum_nxt;
  tapc_pkg::word_t err_r;
  tapc_pkg::word_t sum_r;
  tapc_pkg::word_t diff_r;
  logic signed [tapc_pkg::PROD_W-1:0] prod_p;
  logic signed [tapc_pkg::PROD_W-1:0] prod_i;
  logic signed [tapc_pkg::PROD_W-1:0] prod_d;
  tapc_pkg::tapc_terms_t terms_r;

  assign err_nxt = angle - target;
  assign sum_nxt = error_sum_r + err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else if (ctrl.acc) begin
      error_sum_r <= sum_nxt;
      prev_err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      err_r  <= err_nxt;
      sum_r  <= sum_nxt;
      diff_r <= prev_err_r - err_nxt;
    end
  end

  assign prod_p = tapc_pkg::PROD_W'(gain_p) * tapc_pkg::PROD_W'(err_r);
  assign prod_i = tapc_pkg::PROD_W'(gain_i) * tapc_pkg::PROD_W'(sum_r);
  assign prod_d = tapc_pkg::PROD_W'(gain_d) * tapc_pkg::PROD_W'(diff_r);

  // Only the low word of each shifted product reaches the drive.
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      terms_r.p <= prod_p[tapc_pkg::FRAC_BITS +: tapc_pkg::DATA_W];
      terms_r.i <= prod_i[tapc_pkg::FRAC_BITS +: tapc_pkg::DATA_W];
      terms_r.d <= prod_d[tapc_pkg::FRAC_BITS +: tapc_pkg::DATA_W];
    end
  end

  assign terms = terms_r;

endmodule

/* design/tapc_merge.sv */
// Adds each lane's terms into its drive and holds the result in the output register.
module tapc_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        terms_valid,
  input  tapc_pkg::tapc_terms_t [tapc_pkg::AXES-1:0]  terms,
  output logic                                        terms_ready,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0]  out_tdata
);

  logic out_valid_r;
  logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] out_data_r;
  logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] out_data_nxt;

  assign terms_ready = !out_valid_r || out_tready;

  always_comb begin
    for (int a = 0; a < tapc_pkg::AXES; a++) begin
      out_data_nxt[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W] =
        terms[a].p + terms[a].i + terms[a].d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (terms_ready) begin
      out_valid_r <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (terms_ready && terms_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/three_axis_pid_controller_unit.sv */
// Top level of the three-axis PID controller: register file, lanes and pipeline control.
//
// The input stream carries one measured angle vector per transfer; the output
// stream carries the three motor drives computed from it, one transfer per input.
// Each axis runs in its own lane: the first stage forms the error, updates the
// integral and previous-error state and the derivative difference; the second
// stage multiplies by the three gains; the merge stage adds the terms into the
// output register. A result passes the lane error, lane term and merge output
// registers in turn; one item can be taken every cycle unless the output stalls.
// Every stage holds its item while the next is full, so a stalled receiver
// only stops the input once the pipeline has filled; bubbles are squeezed out.
// Gains and target angles sit in the APB register file, byte address 4 per register.
// The user must write them only while the pipeline is empty; nothing enforces it.
// Reset clears the pipeline, the integral and previous-error state, and loads
// the register defaults: zero gains and targets of 4096, 2048 and 819.
module three_axis_pid_controller_unit (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // angle_x [31:0], angle_y [63:32], angle_z [95:64]
  input  logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // drive_x [31:0], drive_y [63:32], drive_z [95:64]
  output logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] out_tdata,
  input  logic                                       cfg_psel,
  input  logic                                       cfg_penable,
  input  logic                                       cfg_pwrite,
  input  logic [tapc_pkg::ADDR_W-1:0]                cfg_paddr,
  input  logic [tapc_pkg::DATA_W-1:0]                cfg_pwdata,
  output logic [tapc_pkg::DATA_W-1:0]                cfg_prdata,
  output logic                                       cfg_pready
);

  tapc_pkg::word_t gain_p_r;
  tapc_pkg::word_t gain_i_r;
  tapc_pkg::word_t gain_d_r;
  tapc_pkg::word_t target_r [tapc_pkg::AXES];
  tapc_pkg::tapc_reg_t reg_sel;
  logic cfg_wr;

  logic v1_r;
  logic v2_r;
  logic ready1;
  logic ready2;
  logic ready3;
  tapc_pkg::tapc_lane_ctrl_t lane_ctrl;
  tapc_pkg::tapc_terms_t [tapc_pkg::AXES-1:0] terms;

  assign cfg_pready = 1'b1;
  assign reg_sel    = tapc_pkg::tapc_reg_t'(cfg_paddr[tapc_pkg::ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      target_r[0] <= tapc_pkg::word_t'(4096);
      target_r[1] <= tapc_pkg::word_t'(2048);
      target_r[2] <= tapc_pkg::word_t'(819);
    end else if (cfg_wr) begin
      case (reg_sel)
        tapc_pkg::REG_GAIN_P:   gain_p_r    <= cfg_pwdata;
        tapc_pkg::REG_GAIN_I:   gain_i_r    <= cfg_pwdata;
        tapc_pkg::REG_GAIN_D:   gain_d_r    <= cfg_pwdata;
        tapc_pkg::REG_TARGET_X: target_r[0] <= cfg_pwdata;
        tapc_pkg::REG_TARGET_Y: target_r[1] <= cfg_pwdata;
        tapc_pkg::REG_TARGET_Z: target_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tapc_pkg::REG_GAIN_P:   cfg_prdata = gain_p_r;
      tapc_pkg::REG_GAIN_I:   cfg_prdata = gain_i_r;
      tapc_pkg::REG_GAIN_D:   cfg_prdata = gain_d_r;
      tapc_pkg::REG_TARGET_X: cfg_prdata = target_r[0];
      tapc_pkg::REG_TARGET_Y: cfg_prdata = target_r[1];
      tapc_pkg::REG_TARGET_Z: cfg_prdata = target_r[2];
      default:                cfg_prdata = '0;
    endcase
  end

  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;

  assign lane_ctrl.acc = in_tvalid && ready1;
  assign lane_ctrl.adv = v1_r && ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_tvalid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  for (genvar a = 0; a < tapc_pkg::AXES; a++) begin : g_lane
    tapc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .angle  (in_tdata[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W]),
      .target (target_r[a]),
      .gain_p (gain_p_r),
      .gain_i (gain_i_r),
      .gain_d (gain_d_r),
      .terms  (terms[a])
    );
  end

  tapc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .terms_valid (v2_r),
    .terms       (terms),
    .terms_ready (ready3),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

/* design/tapc_checker.sv */
// Port-level checks for the three-axis PID controller and their binding.
module tapc_checker (
  input logic                                       clk,
  input logic                                       rst_n,
  input logic                                       in_tready,
  input logic                                       out_tvalid,
  input logic                                       out_tready,
  input logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] out_tdata,
  input logic                                       cfg_pready
);

  // A result waiting on the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // With no result pending, the input side is never blocked.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port inserted wait state");

endmodule

bind three_axis_pid_controller_unit tapc_checker u_tapc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

/* test/tb_three_axis_pid_controller_unit.sv */
// Self-checking testbench for the three-axis PID controller over its stream and APB ports.
module tb_three_axis_pid_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [tapc_pkg::AXES*tapc_pkg::DATA_W-1:0] vec_t;

  localparam int NUM_REGS       = 6;
  localparam int UNUSED_REG_A   = 6;
  localparam int UNUSED_REG_B   = 7;
  localparam int MAX_GAP        = 14;
  localparam int HOLD_LEN       = 64;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RAND_PHASES    = 7;
  localparam int ITEMS_PER_SET  = 55;
  localparam int PRESSURE_ITEMS = 45;
  localparam tapc_pkg::word_t W_MAX = 32'sh7fff_ffff;
  localparam tapc_pkg::word_t W_MIN = 32'sh8000_0000;
  localparam tapc_pkg::word_t ONE_Q = tapc_pkg::word_t'(1 << tapc_pkg::FRAC_BITS);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  vec_t                in_tdata = '0;   // angle_x [31:0], angle_y [63:32], angle_z [95:64]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  vec_t                out_tdata;       // drive_x [31:0], drive_y [63:32], drive_z [95:64]
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [tapc_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [tapc_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [tapc_pkg::DATA_W-1:0] cfg_prdata;
  logic                cfg_pready;

  three_axis_pid_controller_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vec_t            angle_q[$];
  vec_t            drive_q[$];
  tapc_pkg::word_t shadow_reg [NUM_REGS];
  tapc_pkg::word_t err_integral [tapc_pkg::AXES];
  tapc_pkg::word_t last_err [tapc_pkg::AXES];

  int    items_queued = 0;
  int    angles_sent = 0;
  int    drives_seen = 0;
  int    mismatch_cnt = 0;
  int    reg_writes = 0;
  int    settings_used = 0;
  int    tx_wait = 0;
  int    rx_wait = 0;
  int    hold_left = 0;
  int    hold_req = 0;
  int    hold_ack = 0;
  logic  tx_quiet = 1'b0;
  logic  rx_quiet = 1'b0;

  function automatic longint scaled_term(tapc_pkg::word_t gain, tapc_pkg::word_t value);
    longint prod;
    prod = longint'(gain) * longint'(value);
    return prod >>> tapc_pkg::FRAC_BITS;
  endfunction

  function automatic vec_t pid_drives(vec_t angles);
    tapc_pkg::word_t err;
    tapc_pkg::word_t diff;
    longint          total;
    vec_t            drives;
    for (int a = 0; a < tapc_pkg::AXES; a++) begin
      err = tapc_pkg::word_t'(angles[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W])
            - shadow_reg[tapc_pkg::REG_TARGET_X + a];
      err_integral[a] = err_integral[a] + err;
      diff = last_err[a] - err;
      total = scaled_term(shadow_reg[tapc_pkg::REG_GAIN_P], err)
            + scaled_term(shadow_reg[tapc_pkg::REG_GAIN_I], err_integral[a])
            + scaled_term(shadow_reg[tapc_pkg::REG_GAIN_D], diff);
      drives[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W] = total[tapc_pkg::DATA_W-1:0];
      last_err[a] = err;
    end
    return drives;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_wait   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_q.push_back(pid_drives(in_tdata));
        angles_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          tx_wait   <= tx_wait - 1;
          in_tvalid <= 1'b0;
        end else if (angle_q.size() != 0) begin
          in_tdata  <= angle_q.pop_front();
          in_tvalid <= 1'b1;
          tx_wait   <= tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_ready
    int draw;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      draw = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      rx_wait    <= draw;
      out_tready <= (draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : drive_check
    vec_t            want;
    tapc_pkg::word_t want_w;
    tapc_pkg::word_t got_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected drive transfer: %h", out_tdata);
      end else begin
        want = drive_q.pop_front();
        drives_seen++;
        for (int a = 0; a < tapc_pkg::AXES; a++) begin
          want_w = want[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W];
          got_w  = out_tdata[a*tapc_pkg::DATA_W +: tapc_pkg::DATA_W];
          if (got_w !== want_w) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("Drive mismatch on axis %0d of result %0d: expected %0d, got %0d",
                       a, drives_seen, want_w, got_w);
          end
        end
      end
    end
  end

  task automatic cfg_write(int unsigned idx, tapc_pkg::word_t value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= tapc_pkg::ADDR_W'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx < NUM_REGS)
      shadow_reg[idx] = value;
    reg_writes++;
  endtask

  task automatic load_settings(tapc_pkg::word_t gp, tapc_pkg::word_t gi, tapc_pkg::word_t gd,
                               tapc_pkg::word_t tx, tapc_pkg::word_t ty, tapc_pkg::word_t tz);
    cfg_write(tapc_pkg::REG_GAIN_P, gp);
    cfg_write(tapc_pkg::REG_GAIN_I, gi);
    cfg_write(tapc_pkg::REG_GAIN_D, gd);
    cfg_write(tapc_pkg::REG_TARGET_X, tx);
    cfg_write(tapc_pkg::REG_TARGET_Y, ty);
    cfg_write(tapc_pkg::REG_TARGET_Z, tz);
    settings_used++;
  endtask

  task automatic send_angles(tapc_pkg::word_t ax, tapc_pkg::word_t ay, tapc_pkg::word_t az);
    angle_q.push_back({az, ay, ax});
    items_queued++;
  endtask

  task automatic wait_idle();
    while (angles_sent != items_queued || drive_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tapc_pkg::word_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return W_MAX;
      1: return W_MIN;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic tapc_pkg::word_t rand_setting();
    case ($urandom_range(0, 5))
      0: return pick_extreme();
      1: return tapc_pkg::word_t'(int'($urandom_range(0, 16384)) - 8192);
      2: return $urandom;
      3: return ONE_Q + tapc_pkg::word_t'(int'($urandom_range(0, 8192)) - 4096);
      4: return -ONE_Q;
      default: return tapc_pkg::word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic tapc_pkg::word_t rand_angle(tapc_pkg::word_t tgt);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return tgt + tapc_pkg::word_t'(int'($urandom_range(0, 8192)) - 4096);
      4, 5: return $urandom;
      6: return pick_extreme();
      default: return tgt;
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count)
      send_angles(rand_angle(shadow_reg[tapc_pkg::REG_TARGET_X]),
                  rand_angle(shadow_reg[tapc_pkg::REG_TARGET_Y]),
                  rand_angle(shadow_reg[tapc_pkg::REG_TARGET_Z]));
  endtask

  initial begin
    #2_000_000;
    $display("Run timed out");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    shadow_reg[tapc_pkg::REG_GAIN_P]   = 0;
    shadow_reg[tapc_pkg::REG_GAIN_I]   = 0;
    shadow_reg[tapc_pkg::REG_GAIN_D]   = 0;
    shadow_reg[tapc_pkg::REG_TARGET_X] = 4096;
    shadow_reg[tapc_pkg::REG_TARGET_Y] = 2048;
    shadow_reg[tapc_pkg::REG_TARGET_Z] = 819;
    for (int a = 0; a < tapc_pkg::AXES; a++) begin
      err_integral[a] = 0;
      last_err[a] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    send_angles(0, 0, 0);
    send_angles(W_MAX, W_MIN, -1);
    wait_idle();

    load_settings(ONE_Q, 256, 2048, 1000, -5000, 0);
    send_angles(1000, -5000, 0);
    send_angles(2000, -4000, 100);
    send_angles(W_MAX, W_MIN, -1);
    send_angles(W_MIN, W_MAX, 0);
    send_angles(0, 0, 0);
    send_angles(-1, 1, W_MAX);
    wait_idle();

    load_settings(W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, -1);
    send_angles(W_MIN, W_MAX, W_MIN);
    repeat (4) send_angles(W_MIN, W_MAX, W_MAX);
    send_angles(W_MAX, W_MIN, 0);
    wait_idle();

    load_settings(W_MIN, W_MAX, W_MIN, 0, 0, 0);
    send_angles(W_MAX, W_MIN, 1);
    send_angles(W_MIN, W_MAX, -1);
    send_angles(W_MAX, W_MAX, W_MAX);
    send_angles(W_MIN, W_MIN, W_MIN);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      tx_quiet <= (p % 4 == 1) || (p % 4 == 3);
      rx_quiet <= (p % 4 == 2) || (p % 4 == 3);
      load_settings(rand_setting(), rand_setting(), rand_setting(),
                    rand_setting(), rand_setting(), rand_setting());
      if (p == 0) begin
        cfg_write(UNUSED_REG_A, $urandom);
        cfg_write(UNUSED_REG_B, $urandom);
      end
      send_random(ITEMS_PER_SET);
      wait_idle();
    end

    tx_quiet <= 1'b1;
    rx_quiet <= 1'b0;
    load_settings(rand_setting(), rand_setting(), rand_setting(),
                  rand_setting(), rand_setting(), rand_setting());
    hold_req <= hold_req + 1;
    send_random(PRESSURE_ITEMS);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("Checked %0d drive results from %0d angle vectors under %0d register settings.",
             drives_seen, angles_sent, settings_used);
    $display("Register writes: %0d, including unused addresses and extreme gains and targets.",
             reg_writes);
    if (mismatch_cnt == 0 && drive_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d", mismatch_cnt, drive_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
